/* src/trd_pkg.sv */
// shared types and constants of the tga run-length pixel decoder
// no dependencies; imported by trd_front, trd_back and tga_rle_pixel_decoder
`default_nettype none

package trd_pkg;

    // largest packet a header byte can announce
    localparam int unsigned TRD_MAX_PACKET_PIXELS = 128;

    // depth of the queue between front and back, a power of two of at least 2
    localparam int unsigned TRD_QUEUE_DEPTH = 2;

    // register indexes of the configuration port
    localparam logic [1:0] REG_IMAGE_WIDTH     = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT    = 2'd1;
    localparam logic [1:0] REG_BYTES_PER_PIXEL = 2'd2;

    // one stream byte after classification by the front
    typedef struct packed {
        logic [7:0] stream_byte;
        logic       start_image;
        logic       hdr_is_run;   // header meaning of the byte: run packet
        logic [7:0] hdr_count;    // header meaning of the byte: pixels in packet, 1..128
    } trd_item_t;

    // configuration seen by the back end
    typedef struct packed {
        logic [2:0]  bytes_per_pixel;
        logic [31:0] total_pixels;
    } trd_cfg_t;

endpackage

`default_nettype wire

/* src/trd_front.sv */
// front end: accepts stream bytes, decodes their header meaning, queues them
// depends on trd_pkg
`default_nettype none

module trd_front #(
    parameter int unsigned QUEUE_DEPTH = trd_pkg::TRD_QUEUE_DEPTH
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output      logic              s_ready,
    input  wire logic [7:0]        s_stream_byte,
    input  wire logic              s_start_image,
    output      logic              q_valid,
    input  wire logic              q_ready,
    output      trd_pkg::trd_item_t q_item
);
    import trd_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);

    trd_item_t              entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    trd_item_t              new_item;
    logic                   push, pop;

    // raw header b+1 and run header b-127 both come to b[6:0]+1
    always_comb begin
        new_item.stream_byte = s_stream_byte;
        new_item.start_image = s_start_image;
        new_item.hdr_is_run  = s_stream_byte[7];
        new_item.hdr_count   = {1'b0, s_stream_byte[6:0]} + 8'd1;
    end

    assign s_ready = (count_reg != FULL_COUNT);
    assign q_valid = (count_reg != '0);
    assign q_item  = entry_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

`default_nettype wire

/* src/trd_back.sv */
// back end: packet state, pixel assembly, image count and the result register
// depends on trd_pkg; fed by trd_front
`default_nettype none

module trd_back (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire trd_pkg::trd_cfg_t  cfg,
    input  wire logic               q_valid,
    output      logic               q_ready,
    input  wire trd_pkg::trd_item_t q_item,
    output      logic               m_valid,
    input  wire logic               m_ready,
    output      logic [31:0]        m_pixel_value,
    output      logic [7:0]         m_repeat_count,
    output      logic               m_image_done,
    output      logic               m_overrun_error
);
    import trd_pkg::*;

    logic        expect_header_reg, expect_header_next;
    logic        packet_is_run_reg, packet_is_run_next;
    logic [7:0]  pixels_left_reg, pixels_left_next;
    logic [1:0]  byte_in_pixel_reg, byte_in_pixel_next;
    logic [31:0] color_reg, color_next;
    logic [31:0] decoded_reg, decoded_next;
    logic        stopped_reg, stopped_next;

    logic        m_valid_reg, m_valid_next;
    logic [31:0] pixel_value_reg;
    logic [7:0]  repeat_count_reg;
    logic        image_done_reg, overrun_error_reg;

    // state as seen by this byte, after an optional start clear
    logic        eff_header, eff_run, eff_stopped;
    logic [7:0]  eff_left;
    logic [1:0]  eff_bip;
    logic [31:0] eff_color, eff_decoded;

    logic        take, emit, overrun, done;
    logic [2:0]  pix_size, bip_inc;
    logic [31:0] color_cur;
    logic [7:0]  count, left_after;
    logic [32:0] sum;

    assign q_ready = !m_valid_reg || m_ready;
    assign take    = q_valid && q_ready;

    always_comb begin
        if (cfg.bytes_per_pixel == 3'd0) begin
            pix_size = 3'd1;
        end else if (cfg.bytes_per_pixel > 3'd4) begin
            pix_size = 3'd4;
        end else begin
            pix_size = cfg.bytes_per_pixel;
        end
    end

    always_comb begin
        eff_header  = q_item.start_image ? 1'b1  : expect_header_reg;
        eff_run     = q_item.start_image ? 1'b0  : packet_is_run_reg;
        eff_left    = q_item.start_image ? 8'd0  : pixels_left_reg;
        eff_bip     = q_item.start_image ? 2'd0  : byte_in_pixel_reg;
        eff_color   = q_item.start_image ? 32'd0 : color_reg;
        eff_decoded = q_item.start_image ? 32'd0 : decoded_reg;
        eff_stopped = q_item.start_image ? 1'b0  : stopped_reg;

        color_cur  = ((eff_bip == 2'd0) ? 32'd0 : eff_color)
                   | ({24'd0, q_item.stream_byte} << {eff_bip, 3'b000});
        bip_inc    = {1'b0, eff_bip} + 3'd1;
        count      = (eff_run && eff_left != 8'd0) ? eff_left : 8'd1;
        // overrun when the pixels would carry the count past the image size
        sum        = {1'b0, eff_decoded} + {25'd0, count};
        overrun    = sum > {1'b0, cfg.total_pixels};
        done       = sum == {1'b0, cfg.total_pixels};
        left_after = (eff_left > count) ? eff_left - count : 8'd0;

        expect_header_next = eff_header;
        packet_is_run_next = eff_run;
        pixels_left_next   = eff_left;
        byte_in_pixel_next = eff_bip;
        color_next         = eff_color;
        decoded_next       = eff_decoded;
        stopped_next       = eff_stopped;
        emit               = 1'b0;

        if (!eff_stopped) begin
            if (eff_header) begin
                packet_is_run_next = q_item.hdr_is_run;
                pixels_left_next   = q_item.hdr_count;
                expect_header_next = 1'b0;
                byte_in_pixel_next = 2'd0;
            end else begin
                color_next = color_cur;
                if (bip_inc < pix_size) begin
                    byte_in_pixel_next = bip_inc[1:0];
                end else begin
                    byte_in_pixel_next = 2'd0;
                    emit               = 1'b1;
                    if (overrun) begin
                        stopped_next = 1'b1;
                    end else begin
                        decoded_next     = sum[31:0];
                        pixels_left_next = left_after;
                        if (left_after == 8'd0) begin
                            expect_header_next = 1'b1;
                        end
                        if (done && left_after == 8'd0) begin
                            stopped_next = 1'b1;
                        end
                    end
                end
            end
        end

        m_valid_next = m_valid_reg && !m_ready;
        if (take && emit) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expect_header_reg <= 1'b1;
            packet_is_run_reg <= 1'b0;
            pixels_left_reg   <= 8'd0;
            byte_in_pixel_reg <= 2'd0;
            color_reg         <= 32'd0;
            decoded_reg       <= 32'd0;
            stopped_reg       <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (take) begin
                expect_header_reg <= expect_header_next;
                packet_is_run_reg <= packet_is_run_next;
                pixels_left_reg   <= pixels_left_next;
                byte_in_pixel_reg <= byte_in_pixel_next;
                color_reg         <= color_next;
                decoded_reg       <= decoded_next;
                stopped_reg       <= stopped_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && emit) begin
            pixel_value_reg   <= color_cur;
            repeat_count_reg  <= count;
            image_done_reg    <= !overrun && done;
            overrun_error_reg <= overrun;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_pixel_value   = pixel_value_reg;
    assign m_repeat_count  = repeat_count_reg;
    assign m_image_done    = image_done_reg;
    assign m_overrun_error = overrun_error_reg;

`ifndef NO_ASSERTIONS
    a_overrun_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && emit && overrun) |=> stopped_reg)
        else $error("overrun did not stop the decoder");
    a_done_not_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(image_done_reg && overrun_error_reg))
        else $error("result flags both image done and overrun");
    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (repeat_count_reg != 8'd0))
        else $error("result with zero repeat count");
    a_left_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        {24'd0, pixels_left_reg} <= 32'(TRD_MAX_PACKET_PIXELS))
        else $error("packet pixel count beyond packet limit");
`endif

endmodule

`default_nettype wire

/* src/tga_rle_pixel_decoder.sv */
// top level of the tga run-length pixel decoder: apb registers, front and back
// depends on trd_pkg, trd_front and trd_back
//
//  channel   direction  handshake          payload
//  s_        in         s_valid/s_ready    s_stream_byte, s_start_image
//  m_        out        m_valid/m_ready    m_pixel_value, m_repeat_count,
//                                          m_image_done, m_overrun_error
//  apb       in         psel/penable       paddr, pwdata, prdata (pready tied high)
//
// one stream byte per cycle unless a result stalls, set by the combinational decode
// step in the back end; a result's last byte passes a queue slot, then the result register
// synchronous active-low reset; pixel size applies in the cycle after its write,
// image size only once its register and then the registered product have taken it
// a stalled result blocks the back end only; the front keeps filling its queue
`default_nettype none

module tga_rle_pixel_decoder #(
    parameter int unsigned QUEUE_DEPTH = trd_pkg::TRD_QUEUE_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // byte stream
    input  wire logic        s_valid,
    output      logic        s_ready,
    input  wire logic [7:0]  s_stream_byte,
    input  wire logic        s_start_image,
    // pixel results
    output      logic        m_valid,
    input  wire logic        m_ready,
    output      logic [31:0] m_pixel_value,
    output      logic [7:0]  m_repeat_count,
    output      logic        m_image_done,
    output      logic        m_overrun_error,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output      logic [31:0] prdata,
    output      logic        pready
);
    import trd_pkg::*;

    logic [15:0] image_width_reg, image_width_next;
    logic [15:0] image_height_reg, image_height_next;
    logic [2:0]  bytes_per_pixel_reg, bytes_per_pixel_next;
    logic [31:0] total_pixels_reg, total_pixels_next;
    logic        cfg_write;
    logic [1:0]  reg_index;

    trd_item_t   q_item;
    logic        q_valid, q_ready;
    trd_cfg_t    back_cfg;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    // register write on the access cycle of an apb write transfer
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        image_width_next     = image_width_reg;
        image_height_next    = image_height_reg;
        bytes_per_pixel_next = bytes_per_pixel_reg;
        if (cfg_write) begin
            case (reg_index)
                REG_IMAGE_WIDTH:     image_width_next     = pwdata[15:0];
                REG_IMAGE_HEIGHT:    image_height_next    = pwdata[15:0];
                REG_BYTES_PER_PIXEL: bytes_per_pixel_next = pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            REG_IMAGE_WIDTH:     prdata = {16'd0, image_width_reg};
            REG_IMAGE_HEIGHT:    prdata = {16'd0, image_height_reg};
            REG_BYTES_PER_PIXEL: prdata = {29'd0, bytes_per_pixel_reg};
            default:             prdata = 32'd0;
        endcase
    end

    // image size kept as a registered product, off the decode path
    assign total_pixels_next = {16'd0, image_width_reg} * {16'd0, image_height_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg     <= 16'd1;
            image_height_reg    <= 16'd1;
            bytes_per_pixel_reg <= 3'd4;
            total_pixels_reg    <= 32'd1;
        end else begin
            image_width_reg     <= image_width_next;
            image_height_reg    <= image_height_next;
            bytes_per_pixel_reg <= bytes_per_pixel_next;
            total_pixels_reg    <= total_pixels_next;
        end
    end

    assign back_cfg.bytes_per_pixel = bytes_per_pixel_reg;
    assign back_cfg.total_pixels    = total_pixels_reg;

    // front: accept and classify each byte, then queue it
    trd_front #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_stream_byte (s_stream_byte),
        .s_start_image (s_start_image),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_item        (q_item)
    );

    // back: packet and pixel decode, result register
    trd_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (back_cfg),
        .q_valid         (q_valid),
        .q_ready         (q_ready),
        .q_item          (q_item),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pixel_value   (m_pixel_value),
        .m_repeat_count  (m_repeat_count),
        .m_image_done    (m_image_done),
        .m_overrun_error (m_overrun_error)
    );

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// self-checking bench for tga_rle_pixel_decoder: random and directed byte streams,
// apb register writes between phases, results checked against an in-bench decoder
// depends on trd_pkg and tga_rle_pixel_decoder
module tb_top;

    localparam int unsigned PHASES      = 14;
    localparam int unsigned PHASE_BYTES = 50;
    localparam int unsigned DRAIN_WAIT  = 8;
    localparam int unsigned LONG_HOLD   = 300;
    localparam int unsigned CYCLE_LIMIT = 400000;

    // one byte of the coded stream as the sender offers it
    typedef struct packed {
        logic [7:0] data;
        logic       start;
    } stream_item_t;

    // one decoded pixel transfer
    typedef struct packed {
        logic [31:0] value;
        logic [7:0]  count;
        logic        done;
        logic        overrun;
    } pixel_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_stream_byte = '0;
    logic        s_start_image = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_pixel_value;
    logic [7:0]  m_repeat_count;
    logic        m_image_done;
    logic        m_overrun_error;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    tga_rle_pixel_decoder dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_stream_byte   (s_stream_byte),
        .s_start_image   (s_start_image),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pixel_value   (m_pixel_value),
        .m_repeat_count  (m_repeat_count),
        .m_image_done    (m_image_done),
        .m_overrun_error (m_overrun_error),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // bytes waiting to be offered, and pixels the decoder still owes us
    stream_item_t  stream_q[$];
    pixel_result_t pixel_exp_q[$];

    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;

    // idle percentages of the current phase, changed only at the falling edge
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    // long receiver hold-off: a toggle from the sequence kicks the counter
    logic        hold_kick = 1'b0;
    logic        hold_kick_seen = 1'b0;
    int unsigned hold_left = 0;

    // register copy, as the decoder sees it
    logic [15:0] cfg_width;
    logic [15:0] cfg_height;
    logic [2:0]  cfg_bpp;

    // decoder state
    logic        dec_expect_hdr;
    logic        dec_is_run;
    int unsigned dec_left;
    logic [1:0]  dec_byte_idx;
    logic [31:0] dec_color;
    logic [31:0] dec_pixel_count;
    logic        dec_stopped;

    // phase table: width, height, pixel size register; extremes and odd sizes included
    int unsigned phase_width  [PHASES] = '{4, 7, 3, 5, 16, 1, 65535, 65535, 1, 0, 9, 20, 2, 6};
    int unsigned phase_height [PHASES] = '{3, 5, 3, 4, 16, 1, 65535, 1, 65535, 9, 0, 10, 2, 6};
    int unsigned phase_bpp    [PHASES] = '{1, 3, 4, 2, 0, 5, 4, 7, 3, 1, 6, 1, 3, 4};
    int unsigned mode_send    [4] = '{0, 51, 0, 36};
    int unsigned mode_recv    [4] = '{0, 0, 51, 36};

    function automatic void clear_decoder();
        dec_expect_hdr  = 1'b1;
        dec_is_run      = 1'b0;
        dec_left        = 0;
        dec_byte_idx    = '0;
        dec_color       = '0;
        dec_pixel_count = '0;
        dec_stopped     = 1'b0;
    endfunction

    function automatic int unsigned pixel_bytes(input logic [2:0] bpp);
        if (bpp == 3'd0) return 1;
        if (bpp > 3'd4) return 4;
        return int'(bpp);
    endfunction

    // advance the decoder by one accepted byte, queue the pixel it completes
    function automatic void decode_byte(input logic [7:0] b, input logic start);
        pixel_result_t px;
        int unsigned   nxt;
        int unsigned   cnt;
        logic [31:0]   total;
        logic [31:0]   missing;
        if (start) clear_decoder();
        if (dec_stopped) return;
        // header byte opens a packet and gives no pixel
        if (dec_expect_hdr) begin
            if (b < 8'd128) begin
                dec_is_run = 1'b0;
                dec_left   = int'(b) + 1;
            end else begin
                dec_is_run = 1'b1;
                dec_left   = int'(b) - 127;
            end
            dec_expect_hdr = 1'b0;
            dec_byte_idx   = '0;
            return;
        end
        if (dec_byte_idx == 2'd0) dec_color = '0;
        dec_color = dec_color | (32'(b) << (8 * dec_byte_idx));
        nxt = int'(dec_byte_idx) + 1;
        if (nxt < pixel_bytes(cfg_bpp)) begin
            dec_byte_idx = 2'(nxt);
            return;
        end
        dec_byte_idx = '0;
        cnt = dec_is_run ? dec_left : 1;
        if (cnt == 0) cnt = 1;
        total   = {16'd0, cfg_width} * {16'd0, cfg_height};
        missing = (dec_pixel_count >= total) ? 32'd0 : total - dec_pixel_count;
        px.value = dec_color;
        px.count = 8'(cnt);
        if (cnt > missing) begin
            // packet runs past the image: report and stop
            px.done     = 1'b0;
            px.overrun  = 1'b1;
            dec_stopped = 1'b1;
        end else begin
            dec_pixel_count = dec_pixel_count + cnt;
            dec_left = (dec_left > cnt) ? dec_left - cnt : 0;
            if (dec_left == 0) dec_expect_hdr = 1'b1;
            px.done    = (dec_pixel_count == total);
            px.overrun = 1'b0;
            if (px.done && dec_left == 0) dec_stopped = 1'b1;
        end
        pixel_exp_q.push_back(px);
    endfunction

    function automatic void note_mismatch(input string what, input pixel_result_t want,
                                          input pixel_result_t got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("mismatch (%s): expected value %h count %0d done %0b overrun %0b, got value %h count %0d done %0b overrun %0b",
                     what, want.value, want.count, want.done, want.overrun,
                     got.value, got.count, got.done, got.overrun);
        end
    endfunction

    // byte driver: predicts on every accepted transfer, then offers the next byte
    always @(posedge aclk) begin : byte_driver
        stream_item_t item;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) decode_byte(s_stream_byte, s_start_image);
            // payload only moves once the current transfer is done
            if (!s_valid || s_ready) begin
                if (stream_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    item = stream_q.pop_front();
                    s_valid       <= 1'b1;
                    s_stream_byte <= item.data;
                    s_start_image <= item.start;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // long hold-off counter, owned by this process alone
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left      <= 0;
            hold_kick_seen <= 1'b0;
        end else if (hold_kick != hold_kick_seen) begin
            hold_left      <= LONG_HOLD;
            hold_kick_seen <= hold_kick;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // pixel monitor: checks each result transfer against the oldest expectation
    always @(posedge aclk) begin : pixel_monitor
        pixel_result_t want;
        pixel_result_t got;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got = '{m_pixel_value, m_repeat_count, m_image_done, m_overrun_error};
                if (pixel_exp_q.size() == 0) begin
                    note_mismatch("no pixel expected", '0, got);
                end else begin
                    want = pixel_exp_q.pop_front();
                    if (got.value !== want.value || got.count !== want.count ||
                        got.done !== want.done || got.overrun !== want.overrun)
                        note_mismatch("pixel", want, got);
                end
            end
            m_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // apb write: setup, access, register taken at the end of access
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            trd_pkg::REG_IMAGE_WIDTH:     cfg_width  = value[15:0];
            trd_pkg::REG_IMAGE_HEIGHT:    cfg_height = value[15:0];
            trd_pkg::REG_BYTES_PER_PIXEL: cfg_bpp    = value[2:0];
            default: ;
        endcase
    endtask

    task automatic set_image(input int unsigned w, input int unsigned h, input int unsigned bpp);
        write_reg(trd_pkg::REG_IMAGE_WIDTH, 32'(w));
        write_reg(trd_pkg::REG_IMAGE_HEIGHT, 32'(h));
        write_reg(trd_pkg::REG_BYTES_PER_PIXEL, 32'(bpp));
    endtask

    task automatic push_byte(input logic [7:0] data, input logic start);
        stream_q.push_back('{data, start});
    endtask

    function automatic logic [7:0] pixel_byte();
        case ($urandom_range(9))
            0: return 8'h00;
            1: return 8'hff;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // mostly well-formed images of random packets, with noise bytes and cut packets
    task automatic gen_images(input int unsigned budget);
        longint unsigned total;
        longint unsigned remaining;
        int unsigned     size;
        int unsigned     len;
        int unsigned     nb;
        int unsigned     n_bytes;
        logic            run;
        logic            fresh;
        size      = pixel_bytes(cfg_bpp);
        total     = longint'(cfg_width) * longint'(cfg_height);
        remaining = total;
        fresh     = 1'b1;
        n_bytes   = 0;
        while (n_bytes < budget) begin
            if ($urandom_range(19) == 0) begin
                // stray byte, sometimes flagged as a restart
                push_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
                n_bytes++;
                fresh     = 1'b1;
                remaining = total;
                continue;
            end
            run = $urandom_range(1);
            len = ($urandom_range(7) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 6);
            if (!run && size > 1 && len > 8) len = $urandom_range(1, 8);
            // most packets fit what is left of the image, a few overrun it
            if (remaining != 0 && len > remaining && $urandom_range(7) != 0)
                len = int'(remaining);
            push_byte(run ? 8'(127 + len) : 8'(len - 1), fresh);
            fresh = 1'b0;
            n_bytes++;
            nb = (run ? 1 : len) * size;
            if ($urandom_range(15) == 0) begin
                // cut the packet short; the next image restarts the decoder
                nb = $urandom_range(0, nb - 1);
                fresh     = 1'b1;
                remaining = total;
            end else if (len >= remaining) begin
                fresh     = 1'b1;
                remaining = total;
            end else begin
                remaining = remaining - len;
            end
            repeat (nb) push_byte(pixel_byte(), 1'b0);
            n_bytes += nb;
            // a byte after a finished image is ignored by the stopped decoder
            if (fresh && $urandom_range(3) == 0) push_byte(8'($urandom_range(255)), 1'b0);
        end
    endtask

    // sender holds off until every pixel is in, then lets in-flight bytes settle
    task automatic wait_drained();
        do @(negedge aclk);
        while (stream_q.size() != 0 || s_valid || pixel_exp_q.size() != 0);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    initial begin
        // predictor at its reset values
        cfg_width  = 16'd1;
        cfg_height = 16'd1;
        cfg_bpp    = 3'd4;
        clear_decoder();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed, reset configuration: 1x1 image of 4-byte pixels
        @(negedge aclk);
        push_byte(8'h00, 1'b1);                     // raw packet of one pixel
        repeat (4) push_byte(8'hff, 1'b0);          // completes the image
        push_byte(8'h12, 1'b0);                     // ignored while stopped
        push_byte(8'hff, 1'b1);                     // run of 128 on a 1-pixel image
        repeat (4) push_byte(8'h00, 1'b0);          // overrun
        push_byte(8'h7f, 1'b1);                     // raw packet of 128
        push_byte(8'h01, 1'b0);
        push_byte(8'h02, 1'b0);
        push_byte(8'h03, 1'b0);
        push_byte(8'h04, 1'b0);                     // image done, packet not empty
        push_byte(8'haa, 1'b0);
        push_byte(8'hbb, 1'b0);
        push_byte(8'hcc, 1'b0);
        push_byte(8'hdd, 1'b0);                     // next pixel of the packet overruns
        wait_drained();

        // directed, 3x1 image of 1-byte pixels: shortest runs
        set_image(3, 1, 1);
        @(negedge aclk);
        push_byte(8'h80, 1'b1);                     // run of one
        push_byte(8'h5a, 1'b0);
        push_byte(8'h81, 1'b0);                     // run of two completes the image
        push_byte(8'ha5, 1'b0);
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            set_image(phase_width[p], phase_height[p], phase_bpp[p]);
            @(negedge aclk);
            send_idle_pct  = mode_send[p % 4];
            recv_stall_pct = mode_recv[p % 4];
            // receiver holds off for a long stretch while bytes keep coming
            if (p == 4) hold_kick = ~hold_kick;
            gen_images(PHASE_BYTES);
            wait_drained();
        end

        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
